// ===== src/ljs_pkg.sv =====
// shared types, constants and codes for the jacobi sweep block
package ljs_pkg;

    // fixed field widths
    localparam int VALUE_W    = 17;
    localparam int WEIGHT_W   = 16;
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;

    // stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - STATUS_W;

    localparam int GRID_COLS_DEF = 32;
    localparam int GRID_ROWS_DEF = 32;

    localparam logic [VALUE_W-1:0] VALUE_MAX  = 17'h10000;
    localparam logic [VALUE_W-1:0] VALUE_ZERO = 17'h00000;
    localparam logic [FRAC_W-1:0]  ROUND_HALF = 16'h8000;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_X_WEIGHT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_WEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP     = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_SWEEP   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_SWEEP_DONE   = 2'd0,
        STS_READ_OK      = 2'd1,
        STS_RESTART_DONE = 2'd2,
        STS_BAD_INDEX    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] x_weight;
        logic [WEIGHT_W-1:0] y_weight;
        logic [VALUE_W-1:0]  origin;
        logic [VALUE_W-1:0]  step;
    } ljs_cfg_t;

    localparam ljs_cfg_t CFG_RESET = '{
        x_weight: 16'd6554,
        y_weight: 16'd26214,
        origin:   17'd0,
        step:     17'd2114
    };

    typedef struct packed {
        logic accept;
        logic sweep_start;
        logic sweep_issue;
        logic sweep_end;
        logic restart;
        logic load_result;
    } ljs_cmd_t;

    typedef struct packed {
        logic issue_last;
        logic pipe_busy;
    } ljs_sts_t;

endpackage

// ===== src/ljs_ctrl.sv =====
// controller state machine: item handshake, sweep sequencing, result hand-off
module ljs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ljs_pkg::MODE_W-1:0]    in_mode,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output ljs_pkg::ljs_cmd_t             cmd,
    input  ljs_pkg::ljs_sts_t             sts
);
    import ljs_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg & ~m_tready;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    case (in_mode)
                        MODE_SWEEP: begin
                            cmd.sweep_start = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        MODE_READ: begin
                            state_next = S_READ;
                        end
                        MODE_RESTART: begin
                            cmd.restart = 1'b1;
                            state_next  = S_FINISH;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_READ: begin
                // cell address goes to the memory this cycle
                state_next = S_FINISH;
            end
            S_SWEEP: begin
                cmd.sweep_issue = 1'b1;
                if (sts.issue_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!sts.pipe_busy) begin
                    cmd.sweep_end = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && (!m_valid_reg || m_tready))
            |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded when output register was free");

    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result appeared outside finish");

    a_drain_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN && !sts.pipe_busy) |=> state_reg == S_FINISH)
        else $error("sweep did not finish after pipeline drained");

    a_issue_last_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP && sts.issue_last) |=> state_reg == S_DRAIN)
        else $error("sweep did not stop after the last cell");
`endif

endmodule

// ===== src/ljs_datapath.sv =====
// datapath: grid banks, stencil pipeline, boundary values and result register
module ljs_datapath #(
    parameter int GRID_COLS = ljs_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = ljs_pkg::GRID_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ljs_pkg::ljs_cfg_t              cfg,
    input  ljs_pkg::ljs_cmd_t              cmd,
    output ljs_pkg::ljs_sts_t              sts,
    input  logic [ljs_pkg::MODE_W-1:0]     in_mode,
    input  logic [ljs_pkg::COORD_W-1:0]    in_col,
    input  logic [ljs_pkg::COORD_W-1:0]    in_row,
    output logic [ljs_pkg::VALUE_W-1:0]    m_value,
    output logic [ljs_pkg::STATUS_W-1:0]   m_status
);
    import ljs_pkg::*;

    localparam int CELLS  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int BND_W  = VALUE_W + ROW_W;
    localparam int SUM_W  = VALUE_W + 1;
    localparam int PROD_W = SUM_W + WEIGHT_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND_W  = ACC_W - FRAC_W;

    // grid banks
    logic [VALUE_W-1:0] bank_a_mem [CELLS];
    logic [VALUE_W-1:0] bank_b_mem [CELLS];
    logic [VALUE_W-1:0] a_dn_q_reg, a_up_q_reg, b_dn_q_reg, b_up_q_reg;

    // bank a reads as all zero until a sweep has filled it
    logic cur_reg, zero_a_reg;

    // latched item
    logic [MODE_W-1:0]  item_mode_reg;
    logic [COORD_W-1:0] item_col_reg, item_row_reg;

    // sweep counters
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] lin_reg;
    logic [BND_W-1:0]  bnd_reg;
    logic              col_last, row_last;

    // stencil pipeline
    logic [VALUE_W-1:0] shift_reg [GRID_COLS+1];
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic               s1_write_reg, s2_write_reg, s3_write_reg;
    logic               s1_first_reg, s2_first_reg;
    logic               s1_last_reg, s2_last_reg;
    logic [VALUE_W-1:0] s1_bnd_reg, s2_bnd_reg;
    logic [ADDR_W-1:0]  s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic [PROD_W-1:0]  px_reg, py_reg;
    logic [VALUE_W-1:0] wdata_reg;

    logic [ADDR_W-1:0]  rd_dn_addr, rd_up_addr, item_addr, down_addr, up_addr;
    logic [VALUE_W-1:0] src_dn, src_up, bnd_clamped, wdata_next;
    logic [SUM_W-1:0]   xs, ys;
    logic [PROD_W-1:0]  px_next, py_next;
    logic [ACC_W-1:0]   acc;
    logic [RND_W-1:0]   rounded;
    logic               src_zero;

    logic [IDX_W-1:0]   rd_col_ext, rd_row_ext, phys_row;
    logic               in_range;
    logic [VALUE_W-1:0] value_next;
    status_t            status_next;
    logic [VALUE_W-1:0] m_value_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // ---- item read address ----
    assign rd_col_ext = IDX_W'(item_col_reg);
    assign rd_row_ext = IDX_W'(item_row_reg);
    assign in_range   = (rd_col_ext < IDX_W'(GRID_COLS)) && (rd_row_ext < IDX_W'(GRID_ROWS));

    // first and last rows always mirror their inner neighbors, so only the
    // inner rows are stored
    always_comb begin
        if (rd_row_ext == IDX_W'(0)) begin
            phys_row = IDX_W'(1);
        end else if (rd_row_ext == IDX_W'(GRID_ROWS - 1)) begin
            phys_row = IDX_W'(GRID_ROWS - 2);
        end else begin
            phys_row = rd_row_ext;
        end
    end

    assign item_addr = in_range
        ? ADDR_W'(phys_row) * ADDR_W'(GRID_COLS) + ADDR_W'(rd_col_ext)
        : '0;

    // ---- sweep addresses ----
    assign col_last  = (col_reg == COL_W'(GRID_COLS - 1));
    assign row_last  = (row_reg == ROW_W'(GRID_ROWS - 2));
    assign down_addr = row_last ? lin_reg : lin_reg + ADDR_W'(GRID_COLS);
    assign up_addr   = (row_reg <= ROW_W'(1)) ? lin_reg : lin_reg - ADDR_W'(GRID_COLS);

    assign rd_dn_addr = cmd.sweep_issue ? down_addr : item_addr;
    assign rd_up_addr = up_addr;

    assign sts.issue_last = row_last && col_last;
    assign sts.pipe_busy  = s1_valid_reg | s2_valid_reg | s3_valid_reg;

    // ---- memories ----
    always_ff @(posedge aclk) begin
        if (s3_valid_reg && s3_write_reg && !cur_reg) begin
            bank_b_mem[s3_addr_reg] <= wdata_reg;
        end
        if (s3_valid_reg && s3_write_reg && cur_reg) begin
            bank_a_mem[s3_addr_reg] <= wdata_reg;
        end
        a_dn_q_reg <= bank_a_mem[rd_dn_addr];
        a_up_q_reg <= bank_a_mem[rd_up_addr];
        b_dn_q_reg <= bank_b_mem[rd_dn_addr];
        b_up_q_reg <= bank_b_mem[rd_up_addr];
    end

    assign src_zero = !cur_reg && zero_a_reg;
    assign src_dn   = src_zero ? VALUE_ZERO : (cur_reg ? b_dn_q_reg : a_dn_q_reg);
    assign src_up   = src_zero ? VALUE_ZERO : (cur_reg ? b_up_q_reg : a_up_q_reg);

    // ---- bank state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= 1'b0;
            zero_a_reg <= 1'b1;
        end else if (cmd.restart) begin
            cur_reg    <= 1'b0;
            zero_a_reg <= 1'b1;
        end else if (cmd.sweep_end) begin
            cur_reg <= ~cur_reg;
            if (cur_reg) begin
                zero_a_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_mode_reg <= in_mode;
            item_col_reg  <= in_col;
            item_row_reg  <= in_row;
        end
    end

    // ---- sweep counters; row zero is a priming pass with no writes ----
    always_ff @(posedge aclk) begin
        if (cmd.sweep_start) begin
            col_reg <= '0;
            row_reg <= '0;
            lin_reg <= '0;
            bnd_reg <= BND_W'(cfg.origin);
        end else if (cmd.sweep_issue) begin
            lin_reg <= lin_reg + ADDR_W'(1);
            if (col_last) begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
                bnd_reg <= bnd_reg + BND_W'(cfg.step);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    assign bnd_clamped = (bnd_reg > BND_W'(VALUE_MAX)) ? VALUE_MAX : bnd_reg[VALUE_W-1:0];

    // ---- pipeline control ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.sweep_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: tags alongside the memory read
    always_ff @(posedge aclk) begin
        s1_write_reg <= (row_reg != ROW_W'(0));
        s1_first_reg <= (col_reg == COL_W'(0));
        s1_last_reg  <= col_last;
        s1_bnd_reg   <= bnd_clamped;
        s1_addr_reg  <= lin_reg;
    end

    // down row stream delayed by one row gives the middle row
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            shift_reg[0] <= src_dn;
            for (int k = 1; k <= GRID_COLS; k++) begin
                shift_reg[k] <= shift_reg[k-1];
            end
        end
    end

    // stage 2: neighbor sums and weight products
    assign xs      = SUM_W'(shift_reg[GRID_COLS]) + SUM_W'(shift_reg[GRID_COLS-2]);
    assign ys      = SUM_W'(src_up) + SUM_W'(src_dn);
    assign px_next = xs * cfg.x_weight;
    assign py_next = ys * cfg.y_weight;

    always_ff @(posedge aclk) begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        s2_write_reg <= s1_write_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_bnd_reg   <= s1_bnd_reg;
        s2_addr_reg  <= s1_addr_reg;
    end

    // stage 3: round half up, clamp, pick boundary or stencil value
    assign acc     = ACC_W'(px_reg) + ACC_W'(py_reg) + ACC_W'(ROUND_HALF);
    assign rounded = acc[ACC_W-1:FRAC_W];

    always_comb begin
        if (s2_first_reg) begin
            wdata_next = VALUE_ZERO;
        end else if (s2_last_reg) begin
            wdata_next = s2_bnd_reg;
        end else if (rounded > RND_W'(VALUE_MAX)) begin
            wdata_next = VALUE_MAX;
        end else begin
            wdata_next = rounded[VALUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        wdata_reg    <= wdata_next;
        s3_write_reg <= s2_write_reg;
        s3_addr_reg  <= s2_addr_reg;
    end

    // ---- result ----
    always_comb begin
        value_next = VALUE_ZERO;
        case (item_mode_reg)
            MODE_SWEEP: begin
                status_next = STS_SWEEP_DONE;
            end
            MODE_READ: begin
                if (in_range) begin
                    status_next = STS_READ_OK;
                    value_next  = src_dn;
                end else begin
                    status_next = STS_BAD_INDEX;
                end
            end
            MODE_RESTART: begin
                status_next = STS_RESTART_DONE;
            end
            default: begin
                status_next = STS_BAD_INDEX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_value_reg  <= value_next;
            m_status_reg <= status_next;
        end
    end

    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

endmodule

// ===== src/laplace_jacobi_sweep_2d.sv =====
// top level: stream ports, configuration registers, controller and datapath
// Five-point Jacobi solver for the 2D Laplace equation on a GRID_COLS by
// GRID_ROWS grid of unsigned Q1.16 values held in two ping-pong banks. One item
// is taken at a time and answered with one result. A sweep item streams the
// current bank through a read-multiply-round pipeline at one cell per cycle,
// with one priming row to fill the middle-row delay line. The bank that is
// cleared at reset and on restart is tracked by one flag, so there is no
// clearing pass and the block takes items right after reset. Results wait in
// an output register, so the next item is taken while one is still unread.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user must
// write it only while idle, and the block itself does not enforce this.
module laplace_jacobi_sweep_2d #(
    parameter int GRID_COLS = ljs_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = ljs_pkg::GRID_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ljs_pkg::S_TDATA_W-1:0]     s_tdata,   // mode, col, row, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ljs_pkg::M_TDATA_W-1:0]     m_tdata,   // value, status, zero pad
    input  logic                              cfg_wr_en,
    input  logic [ljs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ljs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ljs_pkg::*;

    ljs_cfg_t            cfg_reg, cfg_next;
    ljs_cmd_t            cmd;
    ljs_sts_t            sts;
    logic [MODE_W-1:0]   in_mode;
    logic [COORD_W-1:0]  in_col, in_row;
    logic [VALUE_W-1:0]  m_value;
    logic [STATUS_W-1:0] m_status;

    assign in_mode = s_tdata[MODE_W-1:0];
    assign in_col  = s_tdata[MODE_W +: COORD_W];
    assign in_row  = s_tdata[MODE_W+COORD_W +: COORD_W];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_X_WEIGHT: cfg_next.x_weight = cfg_wdata[WEIGHT_W-1:0];
                CFG_Y_WEIGHT: cfg_next.y_weight = cfg_wdata[WEIGHT_W-1:0];
                CFG_ORIGIN:   cfg_next.origin   = cfg_wdata[VALUE_W-1:0];
                CFG_STEP:     cfg_next.step     = cfg_wdata[VALUE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ljs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (in_mode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ljs_datapath #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .in_mode  (in_mode),
        .in_col   (in_col),
        .in_row   (in_row),
        .m_value  (m_value),
        .m_status (m_status)
    );

    assign m_tdata = {M_PAD_W'(0), m_status, m_value};

endmodule
